// ===== rtl/sbs_pkg.sv =====
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared types, constants and the microcode table of the sorted byte
// statistics unit.
// ----------------------------------------------------------------------------
package sbs_pkg;

	localparam int MAX_ELEMENTS_DEF = 64;
	localparam int DATA_W           = 8;
	localparam int RANK_W           = 6;
	localparam int SUM_W            = 14;
	localparam int DIV_STEPS        = SUM_W;
	localparam int DCNT_W           = 4;
	localparam int STEP_W           = 4;
	localparam int OUT_TDATA_W      = 48;

	// microprogram step addresses
	localparam logic [STEP_W-1:0] ST_FETCH = 4'd0;
	localparam logic [STEP_W-1:0] ST_CHK   = 4'd1;
	localparam logic [STEP_W-1:0] ST_LOOP  = 4'd2;
	localparam logic [STEP_W-1:0] ST_CMP   = 4'd3;
	localparam logic [STEP_W-1:0] ST_SHIFT = 4'd4;
	localparam logic [STEP_W-1:0] ST_WRITE = 4'd5;
	localparam logic [STEP_W-1:0] ST_DROP  = 4'd6;
	localparam logic [STEP_W-1:0] ST_LASTC = 4'd7;
	localparam logic [STEP_W-1:0] ST_RMAX  = 4'd8;
	localparam logic [STEP_W-1:0] ST_RMIN  = 4'd9;
	localparam logic [STEP_W-1:0] ST_RMEDA = 4'd10;
	localparam logic [STEP_W-1:0] ST_RMEDB = 4'd11;
	localparam logic [STEP_W-1:0] ST_DIV   = 4'd12;
	localparam logic [STEP_W-1:0] ST_OSET  = 4'd13;
	localparam logic [STEP_W-1:0] ST_EMIT  = 4'd14;
	localparam logic [STEP_W-1:0] ST_CLR   = 4'd15;

	typedef enum logic [1:0] {
		W_NONE = 2'd0,
		W_IN   = 2'd1,
		W_OUT  = 2'd2
	} wait_t;

	typedef enum logic [2:0] {
		C_NEVER       = 3'd0,
		C_ALWAYS      = 3'd1,
		C_FULL        = 3'd2,
		C_POS_ZERO    = 3'd3,
		C_NOT_LESS    = 3'd4,
		C_NOT_LAST_IN = 3'd5,
		C_DIV_MORE    = 3'd6,
		C_MORE_OUT    = 3'd7
	} cond_t;

	typedef enum logic [2:0] {
		A_ZERO  = 3'd0,
		A_POSM1 = 3'd1,
		A_NM1   = 3'd2,
		A_NH    = 3'd3,
		A_NHM1  = 3'd4,
		A_KP1   = 3'd5
	} addr_sel_t;

	typedef struct packed {
		wait_t             wt;
		cond_t             br;
		logic [STEP_W-1:0] target;
		logic              in_rdy;
		logic              ld_in;
		logic              pos_init;
		logic              rd_en;
		addr_sel_t         ra;
		logic              shift;
		logic              insert;
		logic              set_drop;
		logic              div_init;
		logic              div_step;
		logic              ld_max;
		logic              ld_min;
		logic              ld_meda;
		logic              ld_med;
		logic              k_init;
		logic              emit;
		logic              clr;
	} ucw_t;

	typedef struct packed {
		ucw_t w;
		logic fire;
	} seq_ctl_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic full;
		logic pos_zero;
		logic less;
		logic last_in;
		logic div_more;
		logic more_out;
	} dp_stat_t;

	// control store
	function automatic ucw_t ucode(input logic [STEP_W-1:0] a);
		ucw_t w;
		w = '0;
		case (a)
			ST_FETCH: begin
				w.wt = W_IN; w.in_rdy = 1'b1; w.ld_in = 1'b1;
			end
			ST_CHK: begin
				w.pos_init = 1'b1; w.br = C_FULL; w.target = ST_DROP;
			end
			ST_LOOP: begin
				w.rd_en = 1'b1; w.ra = A_POSM1; w.br = C_POS_ZERO; w.target = ST_WRITE;
			end
			ST_CMP: begin
				w.br = C_NOT_LESS; w.target = ST_WRITE;
			end
			ST_SHIFT: begin
				w.shift = 1'b1; w.br = C_ALWAYS; w.target = ST_LOOP;
			end
			ST_WRITE: begin
				w.insert = 1'b1; w.br = C_ALWAYS; w.target = ST_LASTC;
			end
			ST_DROP: begin
				w.set_drop = 1'b1;
			end
			ST_LASTC: begin
				w.rd_en = 1'b1; w.ra = A_ZERO; w.div_init = 1'b1;
				w.br = C_NOT_LAST_IN; w.target = ST_FETCH;
			end
			ST_RMAX: begin
				w.ld_max = 1'b1; w.rd_en = 1'b1; w.ra = A_NM1;
			end
			ST_RMIN: begin
				w.ld_min = 1'b1; w.rd_en = 1'b1; w.ra = A_NH;
			end
			ST_RMEDA: begin
				w.ld_meda = 1'b1; w.rd_en = 1'b1; w.ra = A_NHM1;
			end
			ST_RMEDB: begin
				w.ld_med = 1'b1;
			end
			ST_DIV: begin
				w.div_step = 1'b1; w.br = C_DIV_MORE; w.target = ST_DIV;
			end
			ST_OSET: begin
				w.k_init = 1'b1; w.rd_en = 1'b1; w.ra = A_ZERO;
			end
			ST_EMIT: begin
				w.wt = W_OUT; w.emit = 1'b1; w.rd_en = 1'b1; w.ra = A_KP1;
				w.br = C_MORE_OUT; w.target = ST_EMIT;
			end
			ST_CLR: begin
				w.clr = 1'b1; w.br = C_ALWAYS; w.target = ST_FETCH;
			end
			default: begin
				w.br = C_ALWAYS; w.target = ST_FETCH;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/sbs_sequencer.sv =====
// ----------------------------------------------------------------------------
// sbs_sequencer
// Step counter over the control store, with wait and branch evaluation.
// ----------------------------------------------------------------------------
module sbs_sequencer import sbs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_stat_t stat,
	output seq_ctl_t ctl
);

	logic [STEP_W-1:0] pc_q;
	ucw_t              w;
	logic              fire;
	logic              take;

	assign w = ucode(pc_q);

	always_comb begin
		case (w.wt)
			W_NONE:  fire = 1'b1;
			W_IN:    fire = stat.in_valid;
			W_OUT:   fire = stat.out_free;
			default: fire = 1'b0;
		endcase
	end

	always_comb begin
		case (w.br)
			C_NEVER:       take = 1'b0;
			C_ALWAYS:      take = 1'b1;
			C_FULL:        take = stat.full;
			C_POS_ZERO:    take = stat.pos_zero;
			C_NOT_LESS:    take = ~stat.less;
			C_NOT_LAST_IN: take = ~stat.last_in;
			C_DIV_MORE:    take = stat.div_more;
			C_MORE_OUT:    take = stat.more_out;
			default:       take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_FETCH;
		end else if (fire) begin
			pc_q <= take ? w.target : pc_q + 1'b1;
		end
	end

	assign ctl.w    = w;
	assign ctl.fire = fire;

endmodule

// ===== rtl/sbs_datapath.sv =====
// ----------------------------------------------------------------------------
// sbs_datapath
// Element store, insertion pointer, sum, serial divider and result register.
// ----------------------------------------------------------------------------
module sbs_datapath import sbs_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  seq_ctl_t          ctl,
	input  logic              in_valid,
	input  logic [DATA_W-1:0] sample,
	input  logic              last,
	input  logic              out_ready,
	output dp_stat_t          stat,
	output logic              out_valid,
	output logic [DATA_W-1:0] value,
	output logic [RANK_W-1:0] rank,
	output logic [DATA_W-1:0] maximum,
	output logic [DATA_W-1:0] minimum,
	output logic [DATA_W-1:0] mean,
	output logic [DATA_W-1:0] median,
	output logic              overflow,
	output logic              last_result
);

	localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CW = $clog2(MAX_ELEMENTS + 1);

	logic [DATA_W-1:0] mem [MAX_ELEMENTS];

	logic [DATA_W-1:0] sample_q, rd_q, max_q, min_q, meda_q, med_q;
	logic              last_q, drop_q;
	logic [CW-1:0]     pos_q, count_q, rem_q;
	logic [SUM_W-1:0]  sum_q, quo_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [AW-1:0]     k_q;

	logic              f;
	logic [CW-1:0]     pos_m1, n_m1, n_half, n_half_m1;
	logic [AW-1:0]     k_p1, rd_addr, wr_addr;
	logic              we;
	logic [DATA_W-1:0] wd;
	logic [CW:0]       rem_sh, rem_diff;
	logic              rem_ge;
	logic [DATA_W:0]   med_sum;
	logic              out_load;

	assign f         = ctl.fire;
	assign pos_m1    = pos_q - 1'b1;
	assign n_m1      = count_q - 1'b1;
	assign n_half    = count_q >> 1;
	assign n_half_m1 = n_half - 1'b1;
	assign k_p1      = k_q + 1'b1;

	always_comb begin
		case (ctl.w.ra)
			A_ZERO:  rd_addr = '0;
			A_POSM1: rd_addr = pos_m1[AW-1:0];
			A_NM1:   rd_addr = n_m1[AW-1:0];
			A_NH:    rd_addr = n_half[AW-1:0];
			A_NHM1:  rd_addr = n_half_m1[AW-1:0];
			A_KP1:   rd_addr = k_p1;
			default: rd_addr = '0;
		endcase
	end

	// shift moves the compared entry up one slot, insert drops the sample in
	assign we      = f & (ctl.w.shift | ctl.w.insert);
	assign wd      = ctl.w.shift ? rd_q : sample_q;
	assign wr_addr = pos_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wd;
		end
		if (f && ctl.w.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// restoring divider, one quotient bit per step
	assign rem_sh   = {rem_q, quo_q[SUM_W-1]};
	assign rem_ge   = rem_sh >= {1'b0, count_q};
	assign rem_diff = rem_sh - {1'b0, count_q};

	assign med_sum = {1'b0, meda_q} + {1'b0, rd_q};

	always_ff @(posedge clk) begin
		if (f && ctl.w.ld_in) begin
			sample_q <= sample;
			last_q   <= last;
		end
		if (f && ctl.w.ld_max)  max_q  <= rd_q;
		if (f && ctl.w.ld_min)  min_q  <= rd_q;
		if (f && ctl.w.ld_meda) meda_q <= rd_q;
		if (f && ctl.w.ld_med) begin
			med_q <= count_q[0] ? meda_q : med_sum[DATA_W:1];
		end
		if (f && ctl.w.div_init) begin
			rem_q <= '0;
			quo_q <= sum_q;
		end else if (f && ctl.w.div_step) begin
			rem_q <= rem_ge ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
			quo_q <= {quo_q[SUM_W-2:0], rem_ge};
		end
		if (f && ctl.w.k_init) begin
			k_q <= '0;
		end else if (f && ctl.w.emit) begin
			k_q <= k_p1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			count_q <= '0;
			sum_q   <= '0;
			drop_q  <= 1'b0;
			dcnt_q  <= '0;
		end else begin
			if (f && ctl.w.pos_init) begin
				pos_q <= count_q;
			end else if (f && ctl.w.shift) begin
				pos_q <= pos_m1;
			end else if (f && ctl.w.clr) begin
				pos_q <= '0;
			end
			if (f && ctl.w.insert) begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + SUM_W'(sample_q);
			end else if (f && ctl.w.clr) begin
				count_q <= '0;
				sum_q   <= '0;
			end
			if (f && ctl.w.set_drop) begin
				drop_q <= 1'b1;
			end else if (f && ctl.w.clr) begin
				drop_q <= 1'b0;
			end
			if (f && ctl.w.div_init) begin
				dcnt_q <= DCNT_W'(DIV_STEPS);
			end else if (f && ctl.w.div_step) begin
				dcnt_q <= dcnt_q - 1'b1;
			end
		end
	end

	// result register
	assign out_load = f & ctl.w.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value       <= rd_q;
			rank        <= RANK_W'(k_q);
			maximum     <= max_q;
			minimum     <= min_q;
			mean        <= quo_q[DATA_W-1:0];
			median      <= med_q;
			overflow    <= drop_q;
			last_result <= ~stat.more_out;
		end
	end

	assign stat.in_valid = in_valid;
	assign stat.out_free = ~out_valid | out_ready;
	assign stat.full     = count_q == CW'(MAX_ELEMENTS);
	assign stat.pos_zero = pos_q == '0;
	assign stat.less     = rd_q < sample_q;
	assign stat.last_in  = last_q;
	assign stat.div_more = dcnt_q != DCNT_W'(1);
	assign stat.more_out = (CW'(k_q) + 1'b1) != count_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ELEMENTS))
		else $error("element count beyond store depth");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= count_q)
		else $error("insertion pointer beyond element count");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		f && ctl.w.insert |-> count_q < CW'(MAX_ELEMENTS))
		else $error("insert into a full store");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid || out_ready)
		else $error("result register overwritten while held");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		f && ctl.w.clr |=> count_q == '0 && sum_q == '0 && !drop_q)
		else $error("run state not cleared after results");
`endif

endmodule

// ===== rtl/sorted_byte_statistics_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_byte_statistics_unit
// Collects a set of bytes, keeps it sorted in descending order and emits
// every element with its rank plus max, min, floor mean and median.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata                      tuser     tlast
//  s_*      in   sample[7:0]                -         last of the set
//  m_*      out  value,rank,max,min,        overflow  last result of the run
//                mean,median (48 bits)
//
// Steps: a microprogram of 16 steps runs on one store port. A stored
//   element takes one read, one compare and one write for each entry it
//   moves past; a dropped element skips the search and the write.
// After a last transaction: 4 reads of max/min/median, 14 divider steps
//   for the mean, then one result per cycle while m_tready is high, then a clear.
// Reset: arst_n clears the step counter, pointer, count, sum, drop flag, divider count, result valid.
// Stalls: m_tready low holds the emit step while a result is held; the next set is loaded while the
//   final result still waits in the output register.
//
module sorted_byte_statistics_unit import sbs_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [DATA_W-1:0]      s_tdata,   // [7:0] sample
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // value, rank, maximum, minimum, mean, median, pad
	output logic                   m_tuser,   // overflow
	output logic                   m_tlast
);

	seq_ctl_t          ctl;
	dp_stat_t          stat;
	logic [DATA_W-1:0] value, maximum, minimum, mean, median;
	logic [RANK_W-1:0] rank;

	sbs_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	sbs_datapath #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.in_valid    (s_tvalid),
		.sample      (s_tdata),
		.last        (s_tlast),
		.out_ready   (m_tready),
		.stat        (stat),
		.out_valid   (m_tvalid),
		.value       (value),
		.rank        (rank),
		.maximum     (maximum),
		.minimum     (minimum),
		.mean        (mean),
		.median      (median),
		.overflow    (m_tuser),
		.last_result (m_tlast)
	);

	// ready only in the fetch step
	assign s_tready = ctl.w.in_rdy;

	assign m_tdata = {2'b00, median, mean, minimum, maximum, rank, value};

endmodule

// ===== verif/tb_sorted_byte_statistics_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_byte_statistics_unit
// Self-checking bench: byte sets go in on the slave stream and an in-bench
// sorter predicts every ranked result with max, min, floor mean and median.
// Each result transaction is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
module tb_sorted_byte_statistics_unit;
	import sbs_pkg::*;

	localparam int STORE_DEPTH = MAX_ELEMENTS_DEF;
	localparam int CLK_HALF    = 4;
	localparam int RUN_LIMIT   = 600000;
	localparam int HOLD_CYCLES = 800;
	localparam int TAIL_CYCLES = 400;
	localparam int ITEM_TARGET = 480;

	typedef enum int {
		FILL_UNIFORM,
		FILL_POOL,
		FILL_EXTREME,
		FILL_RISING,
		FILL_FALLING
	} fill_mode_t;

	typedef struct {
		logic [DATA_W-1:0] sample;
		logic              last;
		int unsigned       gap;
		bit                drain;
	} feed_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [RANK_W-1:0] rank;
		logic [DATA_W-1:0] maximum;
		logic [DATA_W-1:0] minimum;
		logic [DATA_W-1:0] mean;
		logic [DATA_W-1:0] median;
		logic              overflow;
		logic              last_result;
	} ranked_stat_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [DATA_W-1:0]      s_tdata  = '0;
	logic                   s_tlast  = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;

	// directed sets: single 0, single 255, even pair, equal run,
	// rising run, odd count with duplicates, alternating bit patterns
	int          dir_len   [7]  = '{1, 1, 2, 3, 4, 5, 5};
	logic [7:0]  dir_bytes [21] = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd7, 8'd7, 8'd7,
		8'd1, 8'd2, 8'd3, 8'd4, 8'd250, 8'd128, 8'd3, 8'd128, 8'd64,
		8'd170, 8'd85, 8'd255, 8'd0, 8'd1};

	feed_item_t   feed_q[$];
	ranked_stat_t ranked_q[$];

	// shadow of the sorter
	logic [DATA_W-1:0] shadow_sorted [STORE_DEPTH];
	int unsigned       shadow_count   = 0;
	logic [SUM_W-1:0]  shadow_sum     = '0;
	logic              shadow_dropped = 1'b0;

	int unsigned feed_idle     = 0;
	int unsigned rx_stall      = 0;
	logic        rx_calm       = 1'b0;
	logic        hold_rx       = 1'b0;
	int unsigned results_seen  = 0;
	int unsigned items_taken   = 0;
	int unsigned sets_closed   = 0;
	int unsigned sets_overflow = 0;
	int unsigned mismatches    = 0;
	int unsigned cycle_cnt     = 0;

	sorted_byte_statistics_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// insertion sort into the shadow store; on last, queue the ranked results
	task automatic sort_and_summarize(input logic [DATA_W-1:0] sample, input logic last);
		int unsigned       pos;
		int unsigned       n;
		int unsigned       quot;
		logic [DATA_W:0]   pair;
		logic [DATA_W-1:0] hi;
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] mid;
		ranked_stat_t      r;
		if (shadow_count < STORE_DEPTH) begin
			pos = shadow_count;
			// equal elements keep arrival order
			while (pos > 0 && shadow_sorted[pos-1] < sample) begin
				shadow_sorted[pos] = shadow_sorted[pos-1];
				pos--;
			end
			shadow_sorted[pos] = sample;
			shadow_count++;
			shadow_sum = shadow_sum + sample;
		end else begin
			shadow_dropped = 1'b1;
		end
		if (last) begin
			n    = shadow_count;
			hi   = shadow_sorted[0];
			lo   = shadow_sorted[n-1];
			quot = shadow_sum / n;
			if (n % 2 == 0) begin
				pair = {1'b0, shadow_sorted[n/2]} + {1'b0, shadow_sorted[n/2-1]};
				mid  = pair[DATA_W:1];
			end else begin
				mid = shadow_sorted[n/2];
			end
			for (int unsigned k = 0; k < n; k++) begin
				r.value       = shadow_sorted[k];
				r.rank        = k[RANK_W-1:0];
				r.maximum     = hi;
				r.minimum     = lo;
				r.mean        = quot[DATA_W-1:0];
				r.median      = mid;
				r.overflow    = shadow_dropped;
				r.last_result = (k + 1 == n);
				ranked_q.push_back(r);
			end
			sets_closed++;
			if (shadow_dropped)
				sets_overflow++;
			shadow_count   = 0;
			shadow_sum     = '0;
			shadow_dropped = 1'b0;
		end
	endtask

	task automatic add_item(input logic [DATA_W-1:0] v, input logic l, input int unsigned g,
		input bit d);
		feed_item_t it;
		it.sample = v;
		it.last   = l;
		it.gap    = g;
		it.drain  = d;
		feed_q.push_back(it);
	endtask

	task automatic build_feed();
		int unsigned idx;
		int unsigned len;
		int unsigned pick;
		int unsigned set_no;
		int unsigned built;
		int          base;
		int          step;
		int          acc;
		bit          calm;
		fill_mode_t  mode;
		logic [7:0]  pool [4];
		logic [7:0]  v;
		idx = 0;
		for (int s = 0; s < 7; s++) begin
			for (int i = 0; i < dir_len[s]; i++) begin
				add_item(dir_bytes[idx], i == dir_len[s] - 1,
					(s < 3) ? 0 : $urandom_range(0, 14), 1'b0);
				idx++;
			end
		end
		set_no = 0;
		built  = 0;
		while (built < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			// regular full sets and over-full sets whose excess elements are dropped
			if (set_no % 12 == 5)
				len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 8);
			else if (set_no % 12 == 8)
				len = STORE_DEPTH;
			else if (pick < 70)
				len = $urandom_range(1, 8);
			else if (pick < 90)
				len = $urandom_range(9, 40);
			else
				len = $urandom_range(41, STORE_DEPTH);
			mode = fill_mode_t'($urandom_range(0, 4));
			calm = ($urandom_range(0, 3) == 0);
			for (int p = 0; p < 4; p++)
				pool[p] = 8'($urandom_range(0, 255));
			base = $urandom_range(0, 255);
			step = $urandom_range(0, 4);
			for (int i = 0; i < len; i++) begin
				case (mode)
					FILL_UNIFORM: v = 8'($urandom_range(0, 255));
					FILL_POOL:    v = pool[$urandom_range(0, 3)];
					FILL_EXTREME: begin
						acc = $urandom_range(0, 2);
						v   = $urandom_range(0, 1) ? 8'(255 - acc) : 8'(acc);
					end
					FILL_RISING: begin
						acc = base + i * step;
						v   = (acc > 255) ? 8'd255 : 8'(acc);
					end
					default: begin
						acc = base - i * step;
						v   = (acc < 0) ? 8'd0 : 8'(acc);
					end
				endcase
				// sender waits for a full drain before some sets
				add_item(v, i == len - 1, calm ? 0 : $urandom_range(0, 14),
					(i == 0) && (set_no % 9 == 0));
			end
			built += len;
			set_no++;
		end
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
		input logic [DATA_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// sender: one transaction per queued sample, gap counted from the last acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid  <= 1'b0;
			s_tdata   <= '0;
			s_tlast   <= 1'b0;
			feed_idle <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				sort_and_summarize(s_tdata, s_tlast);
				items_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (feed_q.size() != 0 && feed_idle >= feed_q[0].gap &&
					(!feed_q[0].drain || ranked_q.size() == 0)) begin
					s_tvalid  <= 1'b1;
					s_tdata   <= feed_q[0].sample;
					s_tlast   <= feed_q[0].last;
					feed_idle <= 0;
					void'(feed_q.pop_front());
				end else begin
					s_tvalid <= 1'b0;
					if (feed_q.size() != 0 && feed_idle < feed_q[0].gap)
						feed_idle <= feed_idle + 1;
				end
			end
		end
	end

	// receiver: random stall per result, calm stretches, plus the long hold
	always @(posedge clk or negedge arst_n) begin : rx_side
		int unsigned  nxt;
		ranked_stat_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_stall <= 0;
			rx_calm  <= 1'b0;
		end else begin
			nxt = rx_stall;
			if (m_tvalid && m_tready) begin
				if (ranked_q.size() == 0) begin
					$display("%0t: result with none pending, expected nothing, actual %h",
						$time, m_tdata);
					mismatches++;
				end else begin
					want = ranked_q.pop_front();
					check_field("value",       want.value,       m_tdata[7:0]);
					check_field("rank",        8'(want.rank),    8'(m_tdata[13:8]));
					check_field("maximum",     want.maximum,     m_tdata[21:14]);
					check_field("minimum",     want.minimum,     m_tdata[29:22]);
					check_field("mean",        want.mean,        m_tdata[37:30]);
					check_field("median",      want.median,      m_tdata[45:38]);
					check_field("overflow",    8'(want.overflow),    8'(m_tuser));
					check_field("last_result", 8'(want.last_result), 8'(m_tlast));
				end
				results_seen++;
				if (results_seen % 32 == 0)
					rx_calm <= ($urandom_range(0, 2) == 0);
				nxt = rx_calm ? 0 : $urandom_range(0, 14);
			end else if (nxt != 0) begin
				nxt--;
			end
			rx_stall <= nxt;
			m_tready <= (nxt == 0) && !hold_rx;
		end
	end

	// long receiver hold in the middle of a run's results, while the sender
	// is offering a transaction, so the emit step stalls and input backs up
	initial begin
		wait (results_seen >= 40);
		do
			@(negedge clk);
		while (!(m_tvalid && s_tvalid && ranked_q.size() >= 3));
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= RUN_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results still pending",
				$time, cycle_cnt, ranked_q.size());
			$display("[sorted_byte_statistics_unit] ERROR");
			$finish;
		end
	end

	initial begin
		build_feed();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (feed_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (ranked_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d sets (%0d with dropped elements) from %0d input transactions,",
			sets_closed, sets_overflow, items_taken);
		$display("%0d result transactions checked, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("[sorted_byte_statistics_unit] OK");
		else
			$display("[sorted_byte_statistics_unit] ERROR");
		$finish;
	end

endmodule
